// File: rtl/core/frac_rs_pkg.sv
`timescale 1ns / 1ps

package frac_rs_pkg;

  // Input transaction: one source sample and one monitor sample
  typedef struct packed {
    logic signed [15:0] source_sample;
    logic signed [15:0] monitor_sample;
  } in_t;

  // Output transaction: one resampled sample with run and trigger flags
  typedef struct packed {
    logic signed [15:0] out_sample;
    logic               last_of_run;
    logic               restart_pulse;
  } out_t;

  // Register indexes on the configuration port (paddr[3:2])
  typedef enum logic [1:0] {
    REG_RATE_STEP    = 2'd0,
    REG_TRIGGER_HIGH = 2'd1,
    REG_TRIGGER_LOW  = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  // Register reset values
  localparam logic [15:0]        RATE_STEP_RESET    = 16'd1024;
  localparam logic signed [15:0] TRIGGER_HIGH_RESET = 16'sd16384;
  localparam logic signed [15:0] TRIGGER_LOW_RESET  = 16'sd8192;

  // Upper clamp of the step and longest run per input transaction
  localparam logic [15:0] RATE_CAP = 16'd32768;
  localparam int          MAX_RUN  = 64;

endpackage

// File: rtl/core/fractional_resampler_with_trigger_core.sv
`timescale 1ns / 1ps

// Upsampling (step <= 1.0): each result takes a pass through the shared multiplier
//   (S_MUL), then the output load (S_EMIT_UP); an input of N results, N <= 64, keeps
//   the block busy until its last result is loaded, plus any output stall.
// Decimation (step > 1.0): at most one result per input transaction, loaded in
//   S_EMIT_DEC; no new input is taken until that result is loaded.
// Reset: sync, active high; registers return to defaults, phase/history/trigger clear.
module fractional_resampler_with_trigger_core #(
  parameter int FRAC_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  frac_rs_pkg::in_t   in_data,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output frac_rs_pkg::out_t  out_data,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import frac_rs_pkg::*;

  localparam logic [16:0] UNIT    = 17'(1) << FRAC_BITS;
  localparam int          LO_RAW  = (1 << FRAC_BITS) >> 6;
  localparam logic [15:0] RATE_LO = (LO_RAW < 1) ? 16'd1 : 16'(LO_RAW);
  localparam int          PW      = 18 + FRAC_BITS;   // product width
  localparam int          AW      = PW + 1;           // accumulator width
  localparam int          CW      = $clog2(MAX_RUN);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_EMIT_UP,
    S_EMIT_DEC
  } state_t;

  state_t state;

  // Configuration registers
  logic [15:0]        rate_step;
  logic signed [15:0] trigger_high;
  logic signed [15:0] trigger_low;

  // Block state
  logic [15:0]        phase;
  logic signed [15:0] previous_sample;
  logic signed [15:0] current_sample;
  logic signed [15:0] monitor;
  logic               trigger_armed_off;
  logic [CW-1:0]      count;
  logic signed [PW-1:0] prod;

  // APB writes and reads
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_step    <= RATE_STEP_RESET;
      trigger_high <= TRIGGER_HIGH_RESET;
      trigger_low  <= TRIGGER_LOW_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_RATE_STEP:    rate_step    <= pwdata[15:0];
        REG_TRIGGER_HIGH: trigger_high <= pwdata[15:0];
        REG_TRIGGER_LOW:  trigger_low  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_RATE_STEP:    prdata = {16'd0, rate_step};
      REG_TRIGGER_HIGH: prdata = {{16{trigger_high[15]}}, trigger_high};
      REG_TRIGGER_LOW:  prdata = {{16{trigger_low[15]}}, trigger_low};
      default:          prdata = 32'd0;
    endcase
  end

  // Clamped step
  logic [15:0] rate;
  logic        upsample;

  always_comb begin
    if (rate_step < RATE_LO) begin
      rate = RATE_LO;
    end else if (rate_step > RATE_CAP) begin
      rate = RATE_CAP;
    end else begin
      rate = rate_step;
    end
  end

  assign upsample = {1'b0, rate} <= UNIT;

  // Phase handling at input acceptance
  logic [15:0] up_phase;
  logic        up_empty;
  logic        dec_emit;
  logic [16:0] dec_sum;
  logic [15:0] dec_phase;

  always_comb begin
    up_phase  = ({1'b0, phase} >= UNIT) ? 16'({1'b0, phase} - UNIT) : phase;
    up_empty  = {1'b0, up_phase} >= UNIT;
    dec_emit  = phase >= rate;
    dec_sum   = {1'b0, phase} - (dec_emit ? {1'b0, rate} : 17'd0) + UNIT;
    dec_phase = dec_sum[16] ? 16'hFFFF : dec_sum[15:0];
  end

  // Hysteresis trigger: fire test first, re-arm test second
  logic fire;
  logic armed_off_next;

  always_comb begin
    fire           = (monitor > trigger_high) && !trigger_armed_off;
    armed_off_next = trigger_armed_off || fire;
    if ((monitor < trigger_low) && armed_off_next) begin
      armed_off_next = 1'b0;
    end
  end

  // Shared multiplier operands and interpolation result
  logic signed [16:0]   diff;
  logic signed [FRAC_BITS:0] frac;
  logic signed [AW-1:0] prev_ext;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_adj;
  logic signed [AW-1:0] acc_shr;
  logic signed [15:0]   interp;
  logic [16:0]          phase_step;
  logic                 run_last;
  logic                 out_free;
  logic                 out_load;

  always_comb begin
    diff       = {current_sample[15], current_sample}
               - {previous_sample[15], previous_sample};
    frac       = {1'b0, phase[FRAC_BITS-1:0]};
    prev_ext   = AW'(previous_sample);
    acc        = (prev_ext <<< FRAC_BITS) + AW'(prod);
    // truncate toward zero on the divide by UNIT
    acc_adj    = acc + (acc[AW-1] ? AW'(UNIT - 17'd1) : AW'(0));
    acc_shr    = acc_adj >>> FRAC_BITS;
    interp     = acc_shr[15:0];
    phase_step = {1'b0, phase} + {1'b0, rate};
    run_last   = (phase_step >= UNIT) || (count == CW'(MAX_RUN - 1));
    out_free   = !out_valid || out_ready;
  end

  assign in_ready = (state == S_IDLE);
  assign out_load = out_free && ((state == S_EMIT_UP) || (state == S_EMIT_DEC));

  // Sequencer with output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      phase             <= 16'd0;
      previous_sample   <= 16'sd0;
      current_sample    <= 16'sd0;
      trigger_armed_off <= 1'b0;
      count             <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            monitor        <= in_data.monitor_sample;
            current_sample <= in_data.source_sample;
            count          <= '0;
            if (upsample) begin
              previous_sample <= current_sample;
              phase           <= up_phase;
              state           <= up_empty ? S_IDLE : S_MUL;
            end else begin
              phase <= dec_phase;
              state <= dec_emit ? S_EMIT_DEC : S_IDLE;
            end
          end
        end
        S_MUL: begin
          prod  <= PW'(diff) * PW'(frac);
          state <= S_EMIT_UP;
        end
        S_EMIT_UP: begin
          if (out_free) begin
            out_data.out_sample    <= interp;
            out_data.last_of_run   <= run_last;
            out_data.restart_pulse <= (count == '0) && fire;
            if (count == '0) begin
              trigger_armed_off <= armed_off_next;
            end
            phase <= phase_step[15:0];
            count <= count + CW'(1);
            state <= run_last ? S_IDLE : S_MUL;
          end
        end
        S_EMIT_DEC: begin
          if (out_free) begin
            out_data.out_sample    <= current_sample;
            out_data.last_of_run   <= 1'b1;
            out_data.restart_pulse <= fire;
            trigger_armed_off      <= armed_off_next;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: test/tb_fractional_resampler_with_trigger_core.sv
`timescale 1ns / 1ps

module tb_fractional_resampler_with_trigger_core;
  import frac_rs_pkg::*;

  localparam int          FRAC_BITS     = 10;
  localparam int unsigned ONE           = 1 << FRAC_BITS;
  localparam int          SETTLE_CYCLES = 200;   // covers the longest run of MAX_RUN results
  localparam int          HOLD_CYCLES   = 400;
  localparam int          STALL_LIMIT   = 4000;
  localparam int          SEG_ITEMS     = 16;
  localparam int          HOLD_SEG      = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fractional_resampler_with_trigger_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Resampler state and register copy, as they stand after reset
  logic [15:0]        cfg_rate  = RATE_STEP_RESET;
  logic signed [15:0] cfg_high  = TRIGGER_HIGH_RESET;
  logic signed [15:0] cfg_low   = TRIGGER_LOW_RESET;
  int unsigned        phase_acc = 0;
  logic signed [15:0] hist_prev = '0;
  logic signed [15:0] hist_cur  = '0;
  bit                 trig_off  = 1'b0;

  out_t pending_outs[$];
  int   err_cnt = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  bit   hold_req = 1'b0;

  // Directed plan: register writes and transactions, some with a typed result
  typedef struct {
    bit          is_cfg;
    reg_idx_t    idx;
    logic [15:0] cval;
    in_t         item;
    bit          typed;
    out_t        want;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic void add_item(input logic [15:0] src, input logic [15:0] mon,
                                   input bit typed = 1'b0, input logic [15:0] wsample = '0,
                                   input bit wlast = 1'b0, input bit wpulse = 1'b0);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx = REG_UNUSED;
    r.cval = '0;
    r.item.source_sample = src;
    r.item.monitor_sample = mon;
    r.typed = typed;
    r.want.out_sample = wsample;
    r.want.last_of_run = wlast;
    r.want.restart_pulse = wpulse;
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(input reg_idx_t idx, input logic [15:0] val);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.cval = val;
    r.item = '0;
    r.typed = 1'b0;
    r.want = '0;
    plan.push_back(r);
  endfunction

  // Hysteresis trigger: fire test first, re-arm test second
  function automatic bit trigger_check(input logic signed [15:0] mon);
    int m;
    bit pulse;
    m = mon;
    pulse = 1'b0;
    if (m > int'(cfg_high) && !trig_off) begin
      pulse = 1'b1;
      trig_off = 1'b1;
    end
    if (m < int'(cfg_low) && trig_off)
      trig_off = 1'b0;
    return pulse;
  endfunction

  // Results caused by one input transaction; advances phase, history and trigger
  function automatic void resample_item(input in_t item, output out_t outs[$]);
    int unsigned step;
    int unsigned floor_step;
    int          prev_s;
    int          cur_s;
    int          frac;
    int          acc;
    int          n;
    out_t        r;
    outs.delete();
    floor_step = ((ONE >> 6) < 1) ? 1 : (ONE >> 6);
    step = cfg_rate;
    if (step < floor_step) step = floor_step;
    if (step > RATE_CAP) step = RATE_CAP;
    n = 0;
    if (step <= ONE) begin
      // upsampling: shift history, interpolate until the phase wraps or MAX_RUN results are out
      hist_prev = hist_cur;
      hist_cur = item.source_sample;
      if (phase_acc >= ONE) phase_acc -= ONE;
      while (phase_acc < ONE && n < MAX_RUN) begin
        prev_s = hist_prev;
        cur_s = hist_cur;
        frac = phase_acc;
        acc = prev_s * (int'(ONE) - frac) + cur_s * frac;
        r.out_sample = 16'(acc / int'(ONE));
        r.last_of_run = 1'b0;
        r.restart_pulse = (n == 0) ? trigger_check(item.monitor_sample) : 1'b0;
        outs.push_back(r);
        n++;
        phase_acc += step;
      end
      if (n > 0) outs[n-1].last_of_run = 1'b1;
    end else begin
      // decimation: emit when the phase has reached the step
      hist_cur = item.source_sample;
      if (phase_acc >= step) begin
        r.out_sample = hist_cur;
        r.last_of_run = 1'b1;
        r.restart_pulse = trigger_check(item.monitor_sample);
        outs.push_back(r);
        phase_acc -= step;
      end
      phase_acc += ONE;
      if (phase_acc > 32'hFFFF) phase_acc = 32'hFFFF;
    end
  endfunction

  task automatic note_err(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_xfer(input reg_idx_t idx, input bit wr, input logic [15:0] wval,
                          output logic [15:0] rval);
    bit done;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, wval};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      rval = prdata[15:0];
      @(posedge clk);
    end while (!done);
  endtask

  // Write a register, mirror it, read it back
  task automatic set_reg(input reg_idx_t idx, input logic [15:0] val);
    logic [15:0] back;
    apb_xfer(idx, 1'b1, val, back);
    case (idx)
      REG_RATE_STEP:    cfg_rate = val;
      REG_TRIGGER_HIGH: cfg_high = val;
      REG_TRIGGER_LOW:  cfg_low = val;
      default: ;
    endcase
    apb_xfer(idx, 1'b0, val, back);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx != REG_UNUSED && back !== val)
      note_err($sformatf("readback %s: exp %h got %h", idx.name(), val, back));
  endtask

  // Offer one input transaction, with a random gap in front of it
  task automatic send_item(input in_t item, input bit typed, input out_t want);
    out_t outs[$];
    bit   took;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    resample_item(item, outs);
    if (typed) pending_outs.push_back(want);
    else foreach (outs[j]) pending_outs.push_back(outs[j]);
  endtask

  // Stop sending, wait for every result, then let a silent item finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_outs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Output side: random ready, plus one long hold-off on request
  initial begin : rx_side
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Output check, sampled mid-cycle where all signals are stable
  always @(negedge clk) begin : out_check
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_outs.size() == 0) begin
        note_err($sformatf("unexpected result: sample %0d last %0b pulse %0b",
                           out_data.out_sample, out_data.last_of_run,
                           out_data.restart_pulse));
      end else begin
        want = pending_outs.pop_front();
        if (out_data.out_sample !== want.out_sample ||
            out_data.last_of_run !== want.last_of_run ||
            out_data.restart_pulse !== want.restart_pulse)
          note_err($sformatf({"result mismatch: exp sample %0d last %0b pulse %0b,",
                              " got sample %0d last %0b pulse %0b"},
                             want.out_sample, want.last_of_run, want.restart_pulse,
                             out_data.out_sample, out_data.last_of_run,
                             out_data.restart_pulse));
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_fractional_resampler_with_trigger_core: errors");
    $finish;
  end

  initial begin : stimulus
    int          seg;
    logic [15:0] rate;

    // after reset: step 1.0, one result per item, trigger at 16384 / 8192
    add_item(16'h7FFF, 16'h7FFF, 1'b1, 16'h0000, 1'b1, 1'b1);
    add_item(16'h8000, 16'h8000, 1'b1, 16'h7FFF, 1'b1, 1'b0);
    add_item(16'h0000, 16'h4001, 1'b1, 16'h8000, 1'b1, 1'b1);
    add_item(16'h0001, 16'h4000, 1'b1, 16'h0000, 1'b1, 1'b0);
    // low above high: one sample fires and re-arms
    add_cfg(REG_TRIGGER_HIGH, 16'h8000);
    add_cfg(REG_TRIGGER_LOW, 16'h7FFF);
    add_item(16'd100, 16'h8001);
    add_item(16'd200, 16'h0000);
    add_item(16'd300, 16'h7FFF);
    add_item(16'h8000, 16'h8000);
    // write to the unused index is dropped
    add_cfg(REG_UNUSED, 16'h1234);
    // zero step clamps to the floor: 64 results per item
    add_cfg(REG_RATE_STEP, 16'h0000);
    add_item(16'h7FFF, 16'h7FFF);
    add_item(16'h8000, 16'h8000);
    add_cfg(REG_RATE_STEP, 16'd16);
    add_cfg(REG_TRIGGER_HIGH, 16'h0000);
    add_cfg(REG_TRIGGER_LOW, 16'hFF9C);
    add_item(16'h5555, 16'h0100);
    // step above the cap decimates at 32.0, then back to upsampling with phase left over
    add_cfg(REG_RATE_STEP, 16'hFFFF);
    add_item(16'h1234, 16'h7FFF);
    add_item(16'hEDCB, 16'h8000);
    add_cfg(REG_RATE_STEP, 16'd512);
    add_item(16'h0F0F, 16'h7FFF);
    add_item(16'hF0F0, 16'h8000);
    add_item(16'h2AAA, 16'h7000);
    // decimation just above 1.0, then at the cap
    add_cfg(REG_RATE_STEP, 16'd1025);
    add_item(16'h4000, 16'h8000);
    add_item(16'hC000, 16'h7FFF);
    add_item(16'h0001, 16'hFFFF);
    add_item(16'hFFFF, 16'h0001);
    add_cfg(REG_RATE_STEP, 16'h8000);
    add_item(16'h7FFF, 16'h7FFF);
    add_item(16'h8000, 16'h8000);
    add_cfg(REG_RATE_STEP, RATE_STEP_RESET);
    add_cfg(REG_TRIGGER_HIGH, TRIGGER_HIGH_RESET);
    add_cfg(REG_TRIGGER_LOW, TRIGGER_LOW_RESET);
    add_item(16'h3333, 16'h5000);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 28;
    rx_idle_pct <= 59;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        set_reg(plan[i].idx, plan[i].cval);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    // random segments, each with a fresh setting taken while idle
    for (seg = 0; seg < 6; seg++) begin
      settle();
      case (seg / 2)
        0: begin
          tx_idle_pct = 28;
          rx_idle_pct <= 59;
        end
        1: begin
          tx_idle_pct = 59;
          rx_idle_pct <= 28;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      if (seg == HOLD_SEG) begin
        rate = 16'($urandom_range(1024, 16));
      end else begin
        case ($urandom_range(5))
          0: rate = 16'($urandom_range(15));
          1: rate = 16'($urandom_range(255, 16));
          2: rate = 16'($urandom_range(1024, 256));
          3: rate = 16'($urandom_range(1025, 1024));
          4: rate = 16'($urandom_range(32768, 1026));
          default: rate = 16'($urandom_range(65535, 32769));
        endcase
      end
      set_reg(REG_RATE_STEP, rate);
      set_reg(REG_TRIGGER_HIGH, 16'($urandom));
      set_reg(REG_TRIGGER_LOW, 16'($urandom));
      // block fills while the output side holds off
      if (seg == HOLD_SEG) hold_req <= 1'b1;
      repeat (SEG_ITEMS) send_item(in_t'($urandom), 1'b0, '0);
    end

    settle();
    if (err_cnt == 0 && pending_outs.size() == 0)
      $display("tb_fractional_resampler_with_trigger_core: clean");
    else
      $display("tb_fractional_resampler_with_trigger_core: errors");
    $finish;
  end

endmodule
